@@ rtl/gmmplc_pkg.sv @@
// ----------------------------------------------------------------------------
// GMM pixel classifier package
// Shared constants, types and small lookup functions for the Gaussian
// mixture pixel likelihood classifier.
// ----------------------------------------------------------------------------
package gmmplc_pkg;

   localparam int MAX_COMPONENTS = 8;
   localparam int WORDS_PER_COMP = 10;
   localparam int TABLE_DEPTH    = WORDS_PER_COMP * MAX_COMPONENTS;
   localparam int ADDR_W         = $clog2(TABLE_DEPTH);
   localparam int COMP_W         = $clog2(MAX_COMPONENTS);
   localparam int CNT_W          = $clog2(MAX_COMPONENTS + 1);
   localparam int WORD_W         = 48;
   localparam int LIKE_W         = 48;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [LIKE_W-1:0] like_type;

   localparam logic OP_CLASSIFY = 1'b0;
   localparam logic OP_LOAD     = 1'b1;

   localparam logic [1:0] CLASS_SURE_BG = 2'd0;
   localparam logic [1:0] CLASS_SURE_FG = 2'd1;
   localparam logic [1:0] CLASS_PROB_BG = 2'd2;
   localparam logic [1:0] CLASS_PROB_FG = 2'd3;

   localparam logic [1:0] REG_COMPONENTS = 2'd0;
   localparam logic [1:0] REG_SURE_BG    = 2'd1;
   localparam logic [1:0] REG_PROB_BG    = 2'd2;
   localparam logic [1:0] REG_SURE_FG    = 2'd3;

   localparam logic [3:0] WORD_SCALE = 4'd0;
   localparam logic [3:0] WORD_MEAN0 = 4'd1;
   localparam logic [3:0] WORD_A00   = 4'd4;

   // Reciprocal floor(2^32 / k) for the Taylor term divisors.
   function automatic logic [31:0] recip(input logic [4:0] k);
      logic [31:0] r;
      unique case (k)
         5'd2:    r = 32'h8000_0000;
         5'd3:    r = 32'h5555_5555;
         5'd4:    r = 32'h4000_0000;
         5'd5:    r = 32'h3333_3333;
         5'd6:    r = 32'h2AAA_AAAA;
         5'd7:    r = 32'h2492_4924;
         5'd8:    r = 32'h2000_0000;
         5'd9:    r = 32'h1C71_C71C;
         5'd10:   r = 32'h1999_9999;
         5'd11:   r = 32'h1745_D174;
         5'd12:   r = 32'h1555_5555;
         5'd13:   r = 32'h13B1_3B13;
         5'd14:   r = 32'h1249_2492;
         5'd15:   r = 32'h1111_1111;
         5'd16:   r = 32'h1000_0000;
         default: r = 32'h0;
      endcase
      return r;
   endfunction

   // Slot of the symmetric inverse covariance entry (i, j) in upper-triangle order.
   function automatic logic [2:0] a_slot(input logic [1:0] i, input logic [1:0] j);
      logic [2:0] s;
      unique case ({i, j})
         4'b0000:                   s = 3'd0;
         4'b0001, 4'b0100:          s = 3'd1;
         4'b0010, 4'b1000:          s = 3'd2;
         4'b0101:                   s = 3'd3;
         4'b0110, 4'b1001:          s = 3'd4;
         default:                   s = 3'd5;
      endcase
      return s;
   endfunction

endpackage

@@ rtl/gmmplc_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module gmmplc_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 80
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/gmm_pixel_likelihood_classifier.sv @@
// ----------------------------------------------------------------------------
// GMM pixel likelihood classifier
// Scores RGB pixels against a loaded Gaussian mixture and picks a label.
// ----------------------------------------------------------------------------
// A load request writes one table word; word indexes of 10 or more are
// ignored. A classify request is worked through one component at a time on
// one shared 33x33 multiplier under a small sequencer: the table reads, the
// quadratic form, the Taylor series with its reciprocal divides, the six
// squarings, then the scale and sum. The Taylor series and squarings are
// skipped when the exponent argument is out of range, and the whole
// component when the scale is not positive. A pixel with req_in_mask low
// goes straight to its result. The block takes no request while a pixel is in work.
module gmm_pixel_likelihood_classifier (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_op,
   input  logic [7:0]                     req_chan0,
   input  logic [7:0]                     req_chan1,
   input  logic [7:0]                     req_chan2,
   input  logic                           req_in_mask,
   input  logic [2:0]                     req_comp_index,
   input  logic [3:0]                     req_word_index,
   input  logic signed [gmmplc_pkg::WORD_W-1:0] req_word_value,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [1:0]                     rsp_pixel_class,
   output logic [gmmplc_pkg::LIKE_W-1:0]  rsp_likelihood,
   input  logic                           csr_we,
   input  logic [1:0]                     csr_index,
   input  logic [gmmplc_pkg::WORD_W-1:0]  csr_wdata
);
   import gmmplc_pkg::*;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_FETCH  = 4'd1;
   localparam logic [3:0] ST_QUAD   = 4'd2;
   localparam logic [3:0] ST_EXPCHK = 4'd3;
   localparam logic [3:0] ST_TAYLOR = 4'd4;
   localparam logic [3:0] ST_CLAMP  = 4'd5;
   localparam logic [3:0] ST_SQUARE = 4'd6;
   localparam logic [3:0] ST_SCALE  = 4'd7;
   localparam logic [3:0] ST_NEXT   = 4'd8;
   localparam logic [3:0] ST_DONE   = 4'd9;

   localparam logic [31:0] ONE_Q31 = 32'h8000_0000;

   logic [3:0]              state_ff, state_in;
   logic [CNT_W-1:0]        comp_ff, comp_in, ncomp_ff, ncomp_in;
   logic [3:0]              wcnt_ff, wcnt_in, opc_ff, opc_in;
   logic [1:0]              ph_ff, ph_in;
   logic [4:0]              k_ff, k_in;
   logic [2:0]              sq_ff, sq_in;
   logic                    mask_ff, mask_in;
   logic [7:0]              chan_ff [3];
   logic [7:0]              chan_in [3];
   logic signed [47:0]      scale_ff, scale_in;
   logic signed [24:0]      v_ff [3];
   logic signed [24:0]      v_in [3];
   logic signed [31:0]      a_ff [6];
   logic signed [31:0]      a_in [6];
   logic signed [58:0]      acc_ff, acc_in;
   logic signed [28:0]      w_ff, w_in;
   logic signed [57:0]      q_ff, q_in;
   logic [30:0]             u_ff, u_in;
   logic [31:0]             t_ff, t_in, p_ff, p_in;
   logic signed [33:0]      s_ff, s_in;
   logic [54:0]             hi_ff, hi_in;
   logic [47:0]             contrib_ff, contrib_in;
   like_type                like_ff, like_in;
   logic signed [65:0]      prod_ff;
   logic [CNT_W-1:0]        cfg_ncomp_ff, cfg_ncomp_in;
   like_type                sure_bg_ff, sure_bg_in, prob_bg_ff, prob_bg_in;
   like_type                sure_fg_ff, sure_fg_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [1:0]              rsp_class_ff, rsp_class_in;
   like_type                rsp_like_ff, rsp_like_in;

   logic signed [32:0]      mul_a, mul_b;
   logic                    ram_we;
   logic [ADDR_W-1:0]       ram_waddr, ram_raddr;
   word_type                ram_rdata;
   logic [3:0]              wd;
   logic [1:0]              qi, qj, vidx;
   logic signed [48:0]      vdiff;
   logic signed [47:0]      rword;
   logic signed [58:0]      qsum;
   logic [31:0]             q0;
   logic [36:0]             q0k, rem;
   logic [55:0]             lowsum;
   logic [48:0]             lsum;
   logic                    accept;

   gmmplc_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_DEPTH)) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (req_word_value),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign ram_waddr = ADDR_W'(req_comp_index) * ADDR_W'(WORDS_PER_COMP)
                      + ADDR_W'(req_word_index);
   assign ram_raddr = ADDR_W'(comp_ff[COMP_W-1:0]) * ADDR_W'(WORDS_PER_COMP)
                      + ADDR_W'((wcnt_ff > 4'd9) ? 4'd9 : wcnt_ff);
   assign rword     = $signed(ram_rdata);
   assign wd        = wcnt_ff - 4'd1;
   assign qi        = opc_ff[3:2];
   assign qj        = opc_ff[1:0];
   assign vidx      = (qj == 2'd3) ? qi : qj;
   assign vdiff     = $signed({25'd0, chan_ff[2'(wd - 4'd1)], 16'h0})
                      - $signed({rword[47], rword});
   assign qsum      = acc_ff + prod_ff[58:0];
   assign q0        = prod_ff[63:32];
   assign q0k       = 37'(q0) * 37'(k_ff);
   assign rem       = 37'(p_ff) - q0k;
   assign lowsum    = 56'({hi_ff[6:0], 24'h0}) + prod_ff[55:0];
   assign lsum      = {1'b0, like_ff} + {1'b0, contrib_ff};

   always_comb begin
      state_in     = state_ff;
      comp_in      = comp_ff;
      ncomp_in     = ncomp_ff;
      wcnt_in      = wcnt_ff;
      opc_in       = opc_ff;
      ph_in        = ph_ff;
      k_in         = k_ff;
      sq_in        = sq_ff;
      mask_in      = mask_ff;
      chan_in      = chan_ff;
      scale_in     = scale_ff;
      v_in         = v_ff;
      a_in         = a_ff;
      acc_in       = acc_ff;
      w_in         = w_ff;
      q_in         = q_ff;
      u_in         = u_ff;
      t_in         = t_ff;
      p_in         = p_ff;
      s_in         = s_ff;
      hi_in        = hi_ff;
      contrib_in   = contrib_ff;
      like_in      = like_ff;
      cfg_ncomp_in = cfg_ncomp_ff;
      sure_bg_in   = sure_bg_ff;
      prob_bg_in   = prob_bg_ff;
      sure_fg_in   = sure_fg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_class_in = rsp_class_ff;
      rsp_like_in  = rsp_like_ff;
      mul_a        = '0;
      mul_b        = '0;
      ram_we       = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            REG_COMPONENTS: cfg_ncomp_in = csr_wdata[CNT_W-1:0];
            REG_SURE_BG:    sure_bg_in   = csr_wdata[LIKE_W-1:0];
            REG_PROB_BG:    prob_bg_in   = csr_wdata[LIKE_W-1:0];
            default:        sure_fg_in   = csr_wdata[LIKE_W-1:0];
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_op == OP_LOAD) begin
                  ram_we = (req_word_index < 4'(WORDS_PER_COMP));
               end else begin
                  chan_in[0] = req_chan0;
                  chan_in[1] = req_chan1;
                  chan_in[2] = req_chan2;
                  mask_in    = req_in_mask;
                  like_in    = '0;
                  comp_in    = '0;
                  wcnt_in    = '0;
                  ncomp_in   = (cfg_ncomp_ff > CNT_W'(MAX_COMPONENTS)) ?
                               CNT_W'(MAX_COMPONENTS) : cfg_ncomp_ff;
                  if (!req_in_mask || cfg_ncomp_ff == '0) begin
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_FETCH;
                  end
               end
            end
         end
         ST_FETCH: begin
            wcnt_in = wcnt_ff + 4'd1;
            if (wcnt_ff != 4'd0) begin
               if (wd == WORD_SCALE) begin
                  scale_in = rword;
               end else if (wd < WORD_A00) begin
                  if (vdiff > 49'sd16777215) begin
                     v_in[2'(wd - WORD_MEAN0)] = 25'sd16777215;
                  end else if (vdiff < -49'sd16777215) begin
                     v_in[2'(wd - WORD_MEAN0)] = -25'sd16777215;
                  end else begin
                     v_in[2'(wd - WORD_MEAN0)] = vdiff[24:0];
                  end
               end else begin
                  if (rword > 48'sh7FFF_FFFF) begin
                     a_in[3'(wd - WORD_A00)] = 32'sh7FFF_FFFF;
                  end else if (rword < -48'sh8000_0000) begin
                     a_in[3'(wd - WORD_A00)] = 32'sh8000_0000;
                  end else begin
                     a_in[3'(wd - WORD_A00)] = rword[31:0];
                  end
               end
            end
            if (wcnt_ff == 4'(WORDS_PER_COMP)) begin
               opc_in = '0;
               ph_in  = '0;
               if (scale_ff <= 48'sd0) begin
                  state_in = ST_NEXT;
               end else begin
                  state_in = ST_QUAD;
               end
            end
         end
         ST_QUAD: begin
            if (ph_ff == 2'd0) begin
               if (qj == 2'd3) begin
                  mul_a = 33'(w_ff);
               end else begin
                  mul_a = 33'(a_ff[a_slot(qi, qj)]);
               end
               mul_b = 33'(v_ff[vidx]);
               ph_in = 2'd1;
            end else begin
               unique case (qj)
                  2'd0: acc_in = prod_ff[58:0];
                  2'd1: acc_in = qsum;
                  2'd2: w_in   = qsum[58:30];
                  default: begin
                     if (qi == 2'd0) begin
                        q_in = prod_ff[57:0];
                     end else begin
                        q_in = q_ff + prod_ff[57:0];
                     end
                  end
               endcase
               ph_in  = 2'd0;
               opc_in = opc_ff + 4'd1;
               if (opc_ff == 4'd11) begin
                  state_in = ST_EXPCHK;
               end
            end
         end
         ST_EXPCHK: begin
            ph_in = 2'd0;
            if (q_ff[57] || q_ff[57:39] == '0) begin
               u_in     = q_ff[57] ? '0 : q_ff[38:8];
               t_in     = ONE_Q31;
               s_in     = 34'(ONE_Q31);
               k_in     = 5'd1;
               state_in = ST_TAYLOR;
            end else begin
               t_in     = '0;
               state_in = ST_SCALE;
            end
         end
         ST_TAYLOR: begin
            unique case (ph_ff)
               2'd0: begin
                  mul_a = {1'b0, t_ff};
                  mul_b = {2'b0, u_ff};
                  ph_in = 2'd1;
               end
               2'd1: begin
                  p_in = prod_ff[62:31];
                  if (k_ff == 5'd1) begin
                     t_in  = prod_ff[62:31];
                     ph_in = 2'd3;
                  end else begin
                     mul_a = {1'b0, prod_ff[62:31]};
                     mul_b = {1'b0, recip(k_ff)};
                     ph_in = 2'd2;
                  end
               end
               2'd2: begin
                  t_in  = (rem >= 37'(k_ff)) ? q0 + 32'd1 : q0;
                  ph_in = 2'd3;
               end
               default: begin
                  s_in  = k_ff[0] ? s_ff - $signed(34'(t_ff)) : s_ff + $signed(34'(t_ff));
                  k_in  = k_ff + 5'd1;
                  ph_in = 2'd0;
                  if (k_ff == 5'd16) begin
                     state_in = ST_CLAMP;
                  end
               end
            endcase
         end
         ST_CLAMP: begin
            if (s_ff < 34'sd0) begin
               t_in = '0;
            end else if (s_ff > $signed(34'(ONE_Q31))) begin
               t_in = ONE_Q31;
            end else begin
               t_in = s_ff[31:0];
            end
            sq_in    = '0;
            ph_in    = 2'd0;
            state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            if (ph_ff == 2'd0) begin
               mul_a = {1'b0, t_ff};
               mul_b = {1'b0, t_ff};
               ph_in = 2'd1;
            end else begin
               t_in  = prod_ff[62:31];
               sq_in = sq_ff + 3'd1;
               ph_in = 2'd0;
               if (sq_ff == 3'd5) begin
                  state_in = ST_SCALE;
               end
            end
         end
         ST_SCALE: begin
            unique case (ph_ff)
               2'd0: begin
                  mul_a = {10'b0, scale_ff[46:24]};
                  mul_b = {1'b0, t_ff};
                  ph_in = 2'd1;
               end
               2'd1: begin
                  hi_in = prod_ff[54:0];
                  mul_a = {9'b0, scale_ff[23:0]};
                  mul_b = {1'b0, t_ff};
                  ph_in = 2'd2;
               end
               2'd2: begin
                  contrib_in = hi_ff[54:7] + 48'(lowsum >> 31);
                  ph_in      = 2'd3;
               end
               default: begin
                  like_in  = lsum[48] ? '1 : lsum[LIKE_W-1:0];
                  ph_in    = 2'd0;
                  state_in = ST_NEXT;
               end
            endcase
         end
         ST_NEXT: begin
            comp_in = comp_ff + 1'b1;
            wcnt_in = '0;
            if (comp_ff + 1'b1 == ncomp_ff) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_FETCH;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_like_in  = like_ff;
               if (!mask_ff) begin
                  rsp_class_in = CLASS_SURE_BG;
               end else if (like_ff > sure_bg_ff) begin
                  rsp_class_in = CLASS_SURE_BG;
               end else if (like_ff > prob_bg_ff) begin
                  rsp_class_in = CLASS_PROB_BG;
               end else if (like_ff < sure_fg_ff) begin
                  rsp_class_in = CLASS_SURE_FG;
               end else begin
                  rsp_class_in = CLASS_PROB_FG;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cfg_ncomp_ff <= '0;
         sure_bg_ff   <= '0;
         prob_bg_ff   <= '0;
         sure_fg_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cfg_ncomp_ff <= cfg_ncomp_in;
         sure_bg_ff   <= sure_bg_in;
         prob_bg_ff   <= prob_bg_in;
         sure_fg_ff   <= sure_fg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      comp_ff      <= comp_in;
      ncomp_ff     <= ncomp_in;
      wcnt_ff      <= wcnt_in;
      opc_ff       <= opc_in;
      ph_ff        <= ph_in;
      k_ff         <= k_in;
      sq_ff        <= sq_in;
      mask_ff      <= mask_in;
      chan_ff      <= chan_in;
      scale_ff     <= scale_in;
      v_ff         <= v_in;
      a_ff         <= a_in;
      acc_ff       <= acc_in;
      w_ff         <= w_in;
      q_ff         <= q_in;
      u_ff         <= u_in;
      t_ff         <= t_in;
      p_ff         <= p_in;
      s_ff         <= s_in;
      hi_ff        <= hi_in;
      contrib_ff   <= contrib_in;
      like_ff      <= like_in;
      prod_ff      <= mul_a * mul_b;
      rsp_class_ff <= rsp_class_in;
      rsp_like_ff  <= rsp_like_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_class = rsp_class_ff;
   assign rsp_likelihood  = rsp_like_ff;

`ifndef SYNTH
   a_taylor_k : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TAYLOR) |-> (k_ff >= 5'd1 && k_ff <= 5'd16))
      else $error("Taylor term index out of range");

   a_square_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQUARE) |-> (t_ff <= ONE_Q31))
      else $error("Exponent value above one during squaring");

   a_done_emits : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && (!rsp_valid_ff || rsp_ready)) |=> rsp_valid_ff)
      else $error("Finished pixel did not reach the output register");
`endif

endmodule
